/* hw/rtl/sfp_pkg.sv */
`timescale 1ns / 1ps

package sfp_pkg;

  // Frame layout
  localparam int unsigned FRAME_LEN = 8;
  localparam int unsigned SUM_LEN   = 7;
  localparam int unsigned POS_W     = 3;

  localparam logic [7:0] HDR_FIRST  = 8'hFF;
  localparam logic [7:0] HDR_SECOND = 8'hFE;

  // Byte positions inside a frame
  localparam logic [POS_W-1:0] POS_HUNT   = 3'd0;
  localparam logic [POS_W-1:0] POS_SECOND = 3'd1;
  localparam logic [POS_W-1:0] POS_MASTER = 3'd2;
  localparam logic [POS_W-1:0] POS_ADDR   = 3'd3;
  localparam logic [POS_W-1:0] POS_VALUE1 = 3'd4;
  localparam logic [POS_W-1:0] POS_CHECK  = 3'd7;

  localparam int unsigned SFP_TABLE_ENTRIES = 8;
  localparam int unsigned MAX_ENTRIES       = 8;
  localparam int unsigned INDEX_W           = 3;

  // Configuration register indexes
  localparam logic CFG_MASTER_ADDR = 1'b0;
  localparam logic CFG_DEV_TABLE   = 1'b1;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 32;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture the accepted byte
    logic step;   // run the parser on the captured byte, fill the result register
  } sfp_cmd_t;

endpackage

/* hw/rtl/sync_frame_parser_table_update_top.sv */
`timescale 1ns / 1ps
// Channel   Dir  Signals                       Content
// s_*       in   s_tvalid s_tready s_tdata     one received byte
// m_*       out  m_tvalid m_tready m_tdata     one result item per byte
// cfg_*     in   cfg_we cfg_index cfg_data     register writes, no read-back
//
// Each byte is first captured, then handled in the parser step,
// where the 7-byte checksum adder and the address table search sit.
// A result waits in the output register; the next byte is taken meanwhile,
// and its step holds until that register is free.
// Reset (rst, synchronous) returns the parser to hunting, clears the stored
// entry values, the master address and the address table.

module sync_frame_parser_table_update_top
  import sfp_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = SFP_TABLE_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] rx_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [0] frame_good, [1] checksum_bad, [2] address_unknown, [3] entry_changed,
  // [6:4] entry_index, [14:7] value_first, [22:15] value_second,
  // [30:23] value_third, [31] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic                  cfg_index, // 0 master_address, 1 device_address_table
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  sfp_cmd_t cmd;

  // Sequence capture, step and result hand-off
  sfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // Frame buffer, checksum, table search and value store
  sfp_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tdata   (m_tdata)
  );

  // Good and bad checksum never flag the same item
  a_good_xor_bad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("frame_good and checksum_bad both set");

  // An unknown address stores nothing and reports entry zero
  a_unknown_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2]) |-> (m_tdata[0] && !m_tdata[3] && m_tdata[6:4] == 3'd0))
    else $error("address_unknown with inconsistent flags");

  // A change is only reported for a good frame
  a_change_good: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3]) |-> m_tdata[0])
    else $error("entry_changed without frame_good");

  // One byte at a time: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("byte accepted during parser step");

endmodule

/* hw/rtl/sfp_ctrl.sv */
`timescale 1ns / 1ps

module sfp_ctrl
  import sfp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output sfp_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;
  logic   res_free;

  assign s_tready = (state == ST_IDLE);
  // The result register may be refilled when empty or drained this cycle
  assign res_free = !m_tvalid || m_tready;

  always_comb begin
    cmd.load = (state == ST_IDLE) && s_tvalid;
    cmd.step = (state == ST_EXEC) && res_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (m_tvalid && m_tready) m_tvalid <= 1'b0;
          if (s_tvalid) state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (res_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/sfp_datapath.sv */
`timescale 1ns / 1ps

module sfp_datapath
  import sfp_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = SFP_TABLE_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sfp_cmd_t              cmd,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  logic [7:0]            master_addr;
  logic [CFG_DATA_W-1:0] dev_table;
  logic [7:0]            rx_q;
  logic [POS_W-1:0]      pos;
  logic [POS_W-1:0]      pos_next;
  logic [7:0]            fb      [FRAME_LEN];
  logic [7:0]            fb_next [FRAME_LEN];
  logic [23:0]           entry_values [TABLE_ENTRIES];

  logic [7:0]            sum;
  logic                  done;
  logic                  good;
  logic                  bad;
  logic                  found;
  logic [TABLE_ENTRIES-1:0] first_hit;
  logic [INDEX_W-1:0]    hit_idx;
  logic [23:0]           old_vals;
  logic [23:0]           new_vals;
  logic                  changed;
  logic                  unknown;
  logic [INDEX_W-1:0]    idx_out;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      master_addr <= '0;
      dev_table   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MASTER_ADDR: master_addr <= cfg_data[7:0];
        CFG_DEV_TABLE:   dev_table   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) rx_q <= s_tdata;
  end

  // Parser step on the held byte
  always_comb begin
    for (int i = 0; i < FRAME_LEN; i++) fb_next[i] = fb[i];
    pos_next = POS_HUNT;
    done     = 1'b0;
    sum      = '0;
    for (int i = 0; i < SUM_LEN; i++) sum = sum + fb[i];

    case (pos) inside
      POS_HUNT: begin
        if (rx_q == HDR_FIRST) begin
          fb_next[0] = rx_q;
          pos_next   = POS_SECOND;
        end
      end
      POS_SECOND, POS_MASTER: begin
        if (rx_q == ((pos == POS_SECOND) ? HDR_SECOND : master_addr)) begin
          fb_next[pos] = rx_q;
          pos_next     = pos + POS_W'(1);
        end else if (rx_q == HDR_FIRST) begin
          fb_next[0] = rx_q;
          pos_next   = POS_SECOND;
        end
      end
      default: begin
        fb_next[pos] = rx_q;
        pos_next     = pos + POS_W'(1);
        if (pos == POS_CHECK) begin
          done     = 1'b1;
          pos_next = POS_HUNT;
          if (sum != rx_q) begin
            // Resync on a header prefix in the trailing bytes
            if (fb[4] == HDR_FIRST && fb[5] == HDR_SECOND && fb[6] == master_addr) begin
              fb_next[0] = HDR_FIRST;
              fb_next[1] = HDR_SECOND;
              fb_next[2] = master_addr;
              fb_next[3] = rx_q;
              pos_next   = POS_VALUE1;
            end else if (fb[5] == HDR_FIRST && fb[6] == HDR_SECOND && rx_q == master_addr) begin
              fb_next[0] = HDR_FIRST;
              fb_next[1] = HDR_SECOND;
              fb_next[2] = master_addr;
              pos_next   = POS_ADDR;
            end else if (fb[6] == HDR_FIRST && rx_q == HDR_SECOND) begin
              fb_next[0] = HDR_FIRST;
              fb_next[1] = HDR_SECOND;
              pos_next   = POS_MASTER;
            end else if (rx_q == HDR_FIRST) begin
              fb_next[0] = HDR_FIRST;
              pos_next   = POS_SECOND;
            end
          end
        end
      end
    endcase
  end

  assign good     = done && (sum == rx_q);
  assign bad      = done && (sum != rx_q);
  assign new_vals = {fb[4], fb[5], fb[6]};

  // First matching table entry
  always_comb begin
    found    = 1'b0;
    hit_idx  = '0;
    old_vals = '0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      first_hit[k] = !found && (dev_table[8*k +: 8] == fb[3]);
      if (first_hit[k]) begin
        hit_idx  = INDEX_W'(k);
        old_vals = entry_values[k];
      end
      found = found || first_hit[k];
    end
  end

  assign unknown = good && !found;
  assign changed = good && found && (old_vals != new_vals);
  assign idx_out = (good && found) ? hit_idx : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_HUNT;
      for (int k = 0; k < TABLE_ENTRIES; k++) entry_values[k] <= '0;
    end else if (cmd.step) begin
      pos <= pos_next;
      if (changed) begin
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
          if (first_hit[k]) entry_values[k] <= new_vals;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      for (int i = 0; i < FRAME_LEN; i++) fb[i] <= fb_next[i];
      m_tdata <= {1'b0,
                  done ? new_vals[7:0]   : 8'd0,
                  done ? new_vals[15:8]  : 8'd0,
                  done ? new_vals[23:16] : 8'd0,
                  idx_out, changed, unknown, bad, good};
    end
  end

endmodule
